[hdl/plti_pkg.sv]
package plti_pkg;

  localparam int WL_W  = 16;
  localparam int VAL_W = 18;
  localparam int QUO_W = 36;
  localparam int DSR_W = 16;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 18'sd131071;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -18'sd131072;
  localparam logic signed [VAL_W-1:0] VAL_ONE = 18'sd65536;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_LIMIT_MODE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_MUL,
    S_FEED,
    S_DIV,
    S_WAIT
  } state_t;

  // Word that travels down the divider chain, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [DSR_W-1:0]  rem;
    logic [QUO_W-1:0]  dvd;
    logic [DSR_W-1:0]  dsr;
    logic              neg;
    logic              direct;
    logic              ext;
    logic [VAL_W-1:0]  y0;
  } div_word_t;

endpackage

[hdl/plti_ram.sv]
module plti_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/plti_div_cell.sv]
module plti_div_cell
  import plti_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_word_t din,
  output div_word_t dout
);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  logic [DSR_W:0]   trial;
  logic             fits;
  logic [DSR_W-1:0] rem_next;

  always_comb begin
    trial    = {din.rem, din.dvd[QUO_W-1]};
    fits     = trial >= {1'b0, din.dsr};
    rem_next = fits ? DSR_W'(trial - {1'b0, din.dsr}) : trial[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem    <= rem_next;
    dout.dvd    <= {din.dvd[QUO_W-2:0], fits};
    dout.dsr    <= din.dsr;
    dout.neg    <= din.neg;
    dout.direct <= din.direct;
    dout.ext    <= din.ext;
    dout.y0     <= din.y0;
  end

endmodule

[hdl/piecewise_linear_table_interp_unit.sv]
// Channel  Direction  Handshake              Payload
// in       receive    in_valid / in_stall    opcode, entry_index, entry_wavelength,
//                                            entry_value, query_wavelength
// out      send       out_valid / out_stall  result_value, extrapolated, limited
// cfg      receive    cfg_write              cfg_index, cfg_data
//
// A load word is written into the table memory as it is accepted. A query word scans the
// table in order, each entry with one memory read (S_READ) and one compare (S_CHECK),
// then passes through the multiplier, the divider load and the 36-cell divider chain and
// moves the result into the output register. The table scan and the 36-cell chain take
// up most of the time that a query spends in the block.
// Reset clears the control state and both registers; the table memory is not cleared and
// must be loaded before it is used. A finished result waits in the output register under
// out_stall while the next word is already accepted; a second result then waits inside.
module piecewise_linear_table_interp_unit
  import plti_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic [5:0]              entry_index,
  input  logic [WL_W-1:0]         entry_wavelength,
  input  logic signed [VAL_W-1:0] entry_value,
  input  logic [WL_W-1:0]         query_wavelength,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] result_value,
  output logic                    extrapolated,
  output logic                    limited,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [6:0]              cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int ENT_W = WL_W + VAL_W;

  // Configuration registers.
  logic [6:0] point_count;
  logic       limit_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      limit_mode  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data;
        CFG_LIMIT_MODE:  limit_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A count above the table size acts as the table size.
  logic [CNT_W-1:0] n_used;
  assign n_used = (32'(point_count) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                       : CNT_W'(point_count);

  // Control and scan registers.
  state_t                   state, state_next;
  logic [IDX_W-1:0]         k, k_next;
  logic                     take_next, take_next_next;
  logic [WL_W-1:0]          q, q_next;
  logic [WL_W-1:0]          cx, cx_next, nx, nx_next;
  logic [VAL_W-1:0]         cy, cy_next, ny, ny_next;
  logic                     ext, ext_next;
  logic                     direct, direct_next;
  logic signed [QUO_W-1:0]  prod;
  logic signed [WL_W:0]     den;

  logic                     in_accept;
  logic                     ram_we;
  logic [ENT_W-1:0]         ram_rdata;
  logic [WL_W-1:0]          rd_wl;
  logic [VAL_W-1:0]         rd_val;
  logic                     k_is_last;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign ram_we    = in_accept && (opcode == OP_LOAD) && (32'(entry_index) < 32'(MAX_POINTS));
  assign rd_wl     = ram_rdata[ENT_W-1:VAL_W];
  assign rd_val    = ram_rdata[VAL_W-1:0];
  assign k_is_last = (CNT_W'(k) + CNT_W'(1)) == n_used;

  // Wavelength and value share one memory word.
  plti_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(IDX_W'(entry_index)),
    .wdata({entry_wavelength, entry_value}),
    .raddr(k),
    .rdata(ram_rdata)
  );

  // Divider chain: one quotient bit per cell.
  div_word_t chain [QUO_W+1];
  div_word_t feed;

  logic signed [QUO_W-1:0] prod_mag;
  logic [DSR_W-1:0]        den_mag;

  always_comb begin
    prod_mag    = prod[QUO_W-1] ? -prod : prod;
    den_mag     = den[WL_W] ? DSR_W'(-den) : den[DSR_W-1:0];
    feed.valid  = (state == S_FEED);
    feed.rem    = '0;
    feed.dvd    = prod_mag;
    feed.dsr    = den_mag;
    feed.neg    = prod[QUO_W-1] ^ den[WL_W];
    // A zero-width segment gives its left value.
    feed.direct = direct || (den == '0);
    feed.ext    = ext;
    feed.y0     = cy;
  end

  assign chain[0] = feed;

  for (genvar c = 0; c < QUO_W; c++) begin : g_cell
    plti_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .din (chain[c]),
      .dout(chain[c+1])
    );
  end

  // Add the quotient to the left value, saturate, then limit.
  div_word_t               done;
  logic signed [QUO_W+1:0] quo_s, sum;
  logic signed [VAL_W-1:0] fin_val;
  logic                    fin_lim;

  assign done = chain[QUO_W];

  always_comb begin
    quo_s = $signed({2'b00, done.dvd});
    if (done.direct) begin
      quo_s = '0;
    end else if (done.neg) begin
      quo_s = -quo_s;
    end
    sum     = $signed({{(QUO_W+2-VAL_W){done.y0[VAL_W-1]}}, done.y0}) + quo_s;
    fin_lim = 1'b0;
    fin_val = sum[VAL_W-1:0];
    if (sum > (QUO_W+2)'(VAL_MAX)) begin
      fin_val = VAL_MAX;
      fin_lim = 1'b1;
    end else if (sum < (QUO_W+2)'(VAL_MIN)) begin
      fin_val = VAL_MIN;
      fin_lim = 1'b1;
    end
    if (fin_val < 0) begin
      fin_val = '0;
      fin_lim = 1'b1;
    end
    if (!limit_mode && (fin_val > VAL_ONE)) begin
      fin_val = VAL_ONE;
      fin_lim = 1'b1;
    end
  end

  // Pending result that waits for the output register.
  logic                    p_ext, p_lim;
  logic signed [VAL_W-1:0] p_val;
  logic                    out_load;

  assign out_load = (state == S_WAIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (state == S_DIV && done.valid) begin
      p_val <= fin_val;
      p_ext <= done.ext;
      p_lim <= fin_lim;
    end
    if (out_load) begin
      result_value <= p_val;
      extrapolated <= p_ext;
      limited      <= p_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Multiplier stage.
  logic signed [WL_W:0]  dx;
  logic signed [VAL_W:0] dy;

  assign dx = $signed({1'b0, q}) - $signed({1'b0, cx});
  assign dy = $signed({ny[VAL_W-1], ny}) - $signed({cy[VAL_W-1], cy});

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= QUO_W'(dx * dy);
      den  <= $signed({1'b0, nx}) - $signed({1'b0, cx});
    end
  end

  // State machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      take_next <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      take_next <= take_next_next;
    end
    q      <= q_next;
    cx     <= cx_next;
    cy     <= cy_next;
    nx     <= nx_next;
    ny     <= ny_next;
    ext    <= ext_next;
    direct <= direct_next;
  end

  always_comb begin
    state_next     = state;
    k_next         = k;
    take_next_next = take_next;
    q_next         = q;
    cx_next        = cx;
    cy_next        = cy;
    nx_next        = nx;
    ny_next        = ny;
    ext_next       = ext;
    direct_next    = direct;
    unique case (state)
      S_IDLE: begin
        if (in_accept && opcode == OP_QUERY) begin
          q_next         = query_wavelength;
          k_next         = '0;
          take_next_next = 1'b0;
          ext_next       = 1'b0;
          direct_next    = 1'b0;
          if (n_used == '0) begin
            // An empty table gives zero.
            direct_next = 1'b1;
            cy_next     = '0;
            state_next  = S_MUL;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (n_used == CNT_W'(1)) begin
          direct_next = 1'b1;
          cy_next     = rd_val;
          ext_next    = (q != rd_wl);
          state_next  = S_MUL;
        end else if (take_next) begin
          // Query at or below the first point: use the first two, extrapolating below it.
          nx_next    = rd_wl;
          ny_next    = rd_val;
          state_next = S_MUL;
        end else if (k == '0) begin
          cx_next = rd_wl;
          cy_next = rd_val;
          if (rd_wl >= q) begin
            take_next_next = 1'b1;
            ext_next       = (q < rd_wl);
          end
          k_next     = IDX_W'(1);
          state_next = S_READ;
        end else begin
          nx_next = rd_wl;
          ny_next = rd_val;
          if (rd_wl >= q) begin
            state_next = S_MUL;
          end else if (k_is_last) begin
            // Above the last point: extrapolate from the last two.
            ext_next   = 1'b1;
            state_next = S_MUL;
          end else begin
            cx_next    = rd_wl;
            cy_next    = rd_val;
            k_next     = k + IDX_W'(1);
            state_next = S_READ;
          end
        end
      end
      S_MUL: begin
        state_next = S_FEED;
      end
      S_FEED: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (done.valid) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The chain only ever carries a word while a query waits for it.
  a_chain_in_div: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> state == S_DIV)
    else $error("divider chain produced a word outside the divide state");

  a_feed_to_div: assert property (@(posedge clk) disable iff (rst)
    state == S_FEED |=> state == S_DIV)
    else $error("divider feed not followed by the divide state");

  a_never_negative: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !result_value[VAL_W-1])
    else $error("negative result delivered");

  a_clamp_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && !limit_mode |-> result_value <= VAL_ONE)
    else $error("result above one in clamp mode");

  a_load_in_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("table written while a query is in progress");

endmodule

[bench/tb_piecewise_linear_table_interp_unit.sv]
module tb_piecewise_linear_table_interp_unit;
  import plti_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;
  // A query may take a full table scan plus the multiplier, divider load and
  // the divider chain; this pause covers that with room to spare.
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 60;

  typedef struct {
    logic                    op;
    logic [5:0]              idx;
    logic [WL_W-1:0]         wl;
    logic signed [VAL_W-1:0] val;
    logic [WL_W-1:0]         qwl;
  } word_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    ext;
    logic                    lim;
  } interp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_LOAD;
  logic [5:0] entry_index = '0;
  logic [WL_W-1:0] entry_wavelength = '0;
  logic signed [VAL_W-1:0] entry_value = '0;
  logic [WL_W-1:0] query_wavelength = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] result_value;
  logic extrapolated;
  logic limited;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_POINT_COUNT;
  logic [6:0] cfg_data = '0;

  piecewise_linear_table_interp_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .entry_index(entry_index), .entry_wavelength(entry_wavelength),
    .entry_value(entry_value), .query_wavelength(query_wavelength),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .extrapolated(extrapolated), .limited(limited),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the table, updated as words are queued, and of the registers.
  // The predictor runs when a word is queued; since configuration only
  // changes while the block is idle, queue order equals acceptance order.
  logic [WL_W-1:0]         shadow_wl [TABLE_DEPTH];
  logic signed [VAL_W-1:0] shadow_val [TABLE_DEPTH];
  logic [6:0]              shadow_count = '0;
  logic                    shadow_mode = 1'b0;

  word_t   pending_words[$];
  interp_t expected_results[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  stimulus_done = 1'b0;
  bit  quiet_tail = 1'b0;
  bit  long_hold = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;

  // Stall level seen at the last rising edge, used to tell acceptance.
  logic in_stall_q = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  // Computes the limited interpolation for a query against the shadow table.
  function automatic interp_t interpolate(logic [WL_W-1:0] q);
    interp_t r;
    int n, i, a, b;
    longint v, den;
    r.ext = 1'b0;
    r.lim = 1'b0;
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
    if (n == 0) begin
      v = 0;
    end else if (n == 1) begin
      v = shadow_val[0];
      r.ext = (q != shadow_wl[0]);
    end else begin
      i = 0;
      while (i < n && shadow_wl[i] < q) i++;
      if (i == 0) begin
        a = 0; b = 1;
        r.ext = (q < shadow_wl[0]);
      end else if (i == n) begin
        a = n - 2; b = n - 1;
        r.ext = 1'b1;
      end else begin
        a = i - 1; b = i;
      end
      den = longint'(shadow_wl[b]) - longint'(shadow_wl[a]);
      if (den == 0) v = shadow_val[a];
      else v = longint'(shadow_val[a]) + ((longint'(q) - longint'(shadow_wl[a])) *
               (longint'(shadow_val[b]) - longint'(shadow_val[a]))) / den;
    end
    if (v > 131071) begin v = 131071; r.lim = 1'b1; end
    if (v < -131072) begin v = -131072; r.lim = 1'b1; end
    if (v < 0) begin v = 0; r.lim = 1'b1; end
    if (!shadow_mode && v > 65536) begin v = 65536; r.lim = 1'b1; end
    r.value = VAL_W'(v);
    return r;
  endfunction

  task automatic queue_load(int idx, logic [WL_W-1:0] wl, logic signed [VAL_W-1:0] val);
    word_t w;
    w.op = OP_LOAD; w.idx = 6'(idx); w.wl = wl; w.val = val;
    w.qwl = WL_W'($urandom);
    shadow_wl[idx] = wl;
    shadow_val[idx] = val;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_query(logic [WL_W-1:0] q);
    word_t w;
    w.op = OP_QUERY; w.idx = 6'($urandom); w.wl = WL_W'($urandom);
    w.val = VAL_W'($urandom);
    w.qwl = q;
    expected_results.insert(expected_results.size(), interpolate(q));
    pending_words.insert(pending_words.size(), w);
  endtask

  // Waits until every queued word was taken and every result arrived, then
  // lets the pipeline settle before a register write.
  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen once everything queued so far has drained.
  task automatic write_reg(logic idx, logic [6:0] data);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_POINT_COUNT) shadow_count = data;
    else shadow_mode = data[0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Loads a sorted table of n points with random spacing and values; wide
  // value spread pushes segments into saturation and both limits.
  task automatic load_sorted(int n, bit wide);
    int wl;
    wl = $urandom_range(0, 2000);
    for (int i = 0; i < n; i++) begin
      queue_load(i, wl[WL_W-1:0],
                 wide ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 80000)));
      wl += $urandom_range(0, 65535 / (n + 1));
      if (wl > 65535) wl = 65535;
    end
  endtask

  function automatic logic [WL_W-1:0] pick_query(int n);
    int k;
    k = $urandom_range(0, 9);
    if (n > 0 && k < 5) begin
      k = $urandom_range(0, n - 1);
      return WL_W'(int'(shadow_wl[k]) + int'($urandom_range(0, 20)) - 10);
    end
    if (k == 5) return 16'h0000;
    if (k == 6) return 16'hFFFF;
    return WL_W'($urandom);
  endfunction

  // Stimulus: directed corners, then random phases over several settings.
  initial begin
    int n, phase_items;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table, then a single point, then three points at one wavelength,
    // which form zero-width segments.
    write_reg(CFG_LIMIT_MODE, 7'd0);
    write_reg(CFG_POINT_COUNT, 7'd0);
    queue_query(16'h0000);
    queue_query(16'hFFFF);
    wait_idle();
    queue_load(0, 16'd1000, 18'sd70000);
    queue_load(63, 16'hFFFF, -18'sd131072);
    write_reg(CFG_POINT_COUNT, 7'd1);
    queue_query(16'd1000);
    queue_query(16'd999);
    queue_query(16'hFFFF);
    wait_idle();
    queue_load(1, 16'd1000, 18'sd131071);
    queue_load(2, 16'd1000, 18'sd5);
    write_reg(CFG_POINT_COUNT, 7'd3);
    write_reg(CFG_LIMIT_MODE, 7'd1);
    queue_query(16'd1000);
    queue_query(16'd0);
    queue_query(16'd2000);
    wait_idle();
    // Steep extrapolation saturates in both directions.
    queue_load(0, 16'd100, -18'sd131072);
    queue_load(1, 16'd101, 18'sd131071);
    write_reg(CFG_POINT_COUNT, 7'd2);
    queue_query(16'd0);
    queue_query(16'hFFFF);
    queue_query(16'd101);
    wait_idle();

    // Random phases; the final one is the full table with an oversized count.
    for (int phase = 0; phase < 10; phase++) begin
      n = (phase == 9) ? 64 : (phase % 3 == 0 ? $urandom_range(2, 64) : $urandom_range(0, 12));
      load_sorted(n, (phase % 2) == 1);
      write_reg(CFG_POINT_COUNT, (phase == 9) ? 7'd127 : 7'(n));
      write_reg(CFG_LIMIT_MODE, 7'(phase % 2));
      if (phase == 3) long_hold = 1'b1;
      if (phase == 8) quiet_tail = 1'b1;
      phase_items = (n > 20) ? 100 : 200;
      for (int k = 0; k < phase_items; k++) begin
        if ($urandom_range(0, 9) == 0 && n > 0)
          queue_load($urandom_range(0, n - 1), shadow_wl[$urandom_range(0, n - 1)],
                     VAL_W'($urandom));
        else if (n < TABLE_DEPTH && $urandom_range(0, 19) == 0)
          queue_load($urandom_range(n, TABLE_DEPTH - 1), WL_W'($urandom),
                     VAL_W'($urandom));
        else
          queue_query(pick_query(n));
      end
      wait_idle();
    end
    stimulus_done = 1'b1;
  end

  // Driver: offers the head of the queue, holding it steady until taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        // The previous word was accepted at the last rising edge.
        void'(pending_words.pop_front());
      end
      if (pending_words.size() != 0 && (in_valid || send_gap == 0)) begin
        if (!in_valid && !quiet_tail && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 9);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          opcode <= pending_words[0].op;
          entry_index <= pending_words[0].idx;
          entry_wavelength <= pending_words[0].wl;
          entry_value <= pending_words[0].val;
          query_wavelength <= pending_words[0].qwl;
        end
      end else begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap = send_gap - 1;
      end
    end
  end

  always @(posedge clk) in_stall_q <= in_stall;

  // Receiver stall pattern, with one long hold so the block backs up.
  int hold_count = 0;
  always @(negedge clk) begin
    if (long_hold && hold_count < 400) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else if (quiet_tail) begin
      out_stall <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      recv_gap <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    interp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result word: value %0d ext %0b lim %0b",
                   result_value, extrapolated, limited);
      end else begin
        e = expected_results.pop_front();
        if (e.value !== result_value || e.ext !== extrapolated || e.lim !== limited) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     e.value, e.ext, e.lim, result_value, extrapolated, limited);
        end
      end
    end
  end

  // End of run and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stimulus_done) begin
      if (mismatches == 0 && expected_results.size() == 0)
        $display("piecewise_linear_table_interp_unit test passed");
      else
        $display("piecewise_linear_table_interp_unit test failed");
      $finish;
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("piecewise_linear_table_interp_unit test failed");
      $finish;
    end
  end

endmodule

[filelist.f]
hdl/plti_pkg.sv
hdl/plti_ram.sv
hdl/plti_div_cell.sv
hdl/piecewise_linear_table_interp_unit.sv
bench/tb_piecewise_linear_table_interp_unit.sv
